/* rtl/core/idq_pkg.sv */
`default_nettype none

package idq_pkg;

    // storage geometry
    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // field widths
    localparam int KIND_W = 4;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;
    localparam int ENT_W  = 7;

    // operation codes
    localparam logic [KIND_W-1:0] K_PUSH_FRONT = 4'd0;
    localparam logic [KIND_W-1:0] K_PUSH_BACK  = 4'd1;
    localparam logic [KIND_W-1:0] K_INSERT_AT  = 4'd2;
    localparam logic [KIND_W-1:0] K_POP_FRONT  = 4'd3;
    localparam logic [KIND_W-1:0] K_POP_BACK   = 4'd4;
    localparam logic [KIND_W-1:0] K_REMOVE_AT  = 4'd5;
    localparam logic [KIND_W-1:0] K_CLEAR      = 4'd6;
    localparam logic [KIND_W-1:0] K_READ_FWD   = 4'd7;
    localparam logic [KIND_W-1:0] K_READ_BWD   = 4'd8;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    // one result beat
    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        logic [STAT_W-1:0] status;
        logic              last;
        logic [ENT_W-1:0]  entries_now;
    } res_t;

endpackage

`default_nettype wire

/* rtl/core/idq_ram.sv */
`default_nettype none

// simple dual-port RAM, registered read
module idq_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/idq_outreg.sv */
`default_nettype none

// one-deep result register in front of the master port
module idq_outreg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire idq_pkg::res_t res_in,
    output logic               space,
    output logic               out_valid,
    input  wire logic          out_ready,
    output idq_pkg::res_t      res_out
);
    import idq_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

`default_nettype wire

/* rtl/core/idq_ctrl.sv */
`default_nettype none

// operation sequencer: decodes one op, shifts entries through the RAM,
// streams read-outs
module idq_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [idq_pkg::KIND_W-1:0]  in_kind,
    input  wire logic [idq_pkg::VAL_W-1:0]   in_value,
    input  wire logic [idq_pkg::POS_W-1:0]   in_pos,
    output logic                             res_push,
    input  wire logic                        res_space,
    output idq_pkg::res_t                    res,
    output logic                             mem_we,
    output logic [idq_pkg::ADDR_W-1:0]       mem_waddr,
    output logic [idq_pkg::VAL_W-1:0]        mem_wdata,
    output logic                             mem_re,
    output logic [idq_pkg::ADDR_W-1:0]       mem_raddr,
    input  wire logic [idq_pkg::VAL_W-1:0]   mem_rdata
);
    import idq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_SHIFT    = 5'b00010,
        S_RD_ISSUE = 5'b00100,
        S_RD_WAIT  = 5'b01000,
        S_RESP     = 5'b10000
    } state_t;

    state_t             state_reg,  state_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic [ADDR_W-1:0]  src_reg,    src_next;
    logic [ADDR_W-1:0]  stop_reg,   stop_next;
    logic [ADDR_W-1:0]  idx_reg,    idx_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0]  rd_i_reg,   rd_i_next;
    logic               pend_reg,   pend_next;
    logic               issue_reg,  issue_next;
    logic               up_reg,     up_next;
    logic               back_reg,   back_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [VAL_W-1:0]   val_reg,    val_next;

    logic               accept;
    logic               full;
    logic               empty;
    logic [POS_W-1:0]   cnt_ext;
    logic [POS_W-1:0]   ins_idx;
    logic [POS_W-1:0]   rm_idx;
    logic               rm_bad;
    logic [CNT_W-1:0]   cnt_m1_full;
    logic [ADDR_W-1:0]  cnt_m1;
    logic               rd_last;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign full        = (count_reg == CNT_W'(CAPACITY));
    assign empty       = (count_reg == '0);
    assign cnt_ext     = POS_W'(count_reg);
    assign cnt_m1_full = count_reg - CNT_W'(1);
    assign cnt_m1      = cnt_m1_full[ADDR_W-1:0];
    assign rd_last     = (rd_i_reg == cnt_m1);

    // insert index: past the end appends
    always_comb
    begin
        ins_idx = '0;
        if (in_kind == K_PUSH_BACK)
        begin
            ins_idx = cnt_ext;
        end
        else if (in_kind == K_INSERT_AT)
        begin
            ins_idx = (in_pos > cnt_ext) ? cnt_ext : in_pos;
        end
    end

    always_comb
    begin
        rm_idx = '0;
        if (in_kind == K_POP_BACK)
        begin
            rm_idx = cnt_ext - POS_W'(1);
        end
        else if (in_kind == K_REMOVE_AT)
        begin
            rm_idx = in_pos;
        end
    end

    assign rm_bad = ((in_kind == K_REMOVE_AT) && in_pos[POS_W-1]) || empty ||
                    (rm_idx >= cnt_ext);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        src_next       = src_reg;
        stop_next      = stop_reg;
        idx_next       = idx_reg;
        pend_addr_next = pend_addr_reg;
        rd_i_next      = rd_i_reg;
        pend_next      = pend_reg;
        issue_next     = issue_reg;
        up_next        = up_reg;
        back_next      = back_reg;
        status_next    = status_reg;
        val_next       = val_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        res_push       = 1'b0;
        res            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_OK;
                    state_next  = S_RESP;
                    case (in_kind)
                        K_PUSH_FRONT, K_PUSH_BACK, K_INSERT_AT:
                        begin
                            if ((in_kind == K_INSERT_AT) && in_pos[POS_W-1])
                            begin
                                status_next = ST_IGNORED;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                val_next   = in_value;
                                idx_next   = ins_idx[ADDR_W-1:0];
                                if (ins_idx == cnt_ext)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = ins_idx[ADDR_W-1:0];
                                    mem_wdata = in_value;
                                end
                                else
                                begin
                                    // move [idx, count-1] up by one, top first
                                    src_next   = cnt_m1;
                                    stop_next  = ins_idx[ADDR_W-1:0];
                                    up_next    = 1'b1;
                                    issue_next = 1'b1;
                                    pend_next  = 1'b0;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        K_POP_FRONT, K_POP_BACK, K_REMOVE_AT:
                        begin
                            if (rm_bad)
                            begin
                                status_next = ST_IGNORED;
                            end
                            else
                            begin
                                count_next = cnt_m1_full;
                                if ((rm_idx + POS_W'(1)) != cnt_ext)
                                begin
                                    // move [idx+1, count-1] down by one, bottom first
                                    src_next   = rm_idx[ADDR_W-1:0] + ADDR_W'(1);
                                    stop_next  = cnt_m1;
                                    up_next    = 1'b0;
                                    issue_next = 1'b1;
                                    pend_next  = 1'b0;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        K_CLEAR:
                        begin
                            count_next = '0;
                        end
                        K_READ_FWD, K_READ_BWD:
                        begin
                            if (empty)
                            begin
                                status_next = ST_IGNORED;
                            end
                            else
                            begin
                                rd_i_next  = '0;
                                back_next  = (in_kind == K_READ_BWD);
                                state_next = S_RD_ISSUE;
                            end
                        end
                        default:
                        begin
                            status_next = ST_IGNORED;
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // write back the word read last cycle
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = mem_rdata;
                end
                if (issue_reg)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = src_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = up_reg ? (src_reg + ADDR_W'(1))
                                            : (src_reg - ADDR_W'(1));
                    if (src_reg == stop_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        src_next = up_reg ? (src_reg - ADDR_W'(1))
                                          : (src_reg + ADDR_W'(1));
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (up_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_reg;
                            mem_wdata = val_reg;
                        end
                        state_next = S_RESP;
                    end
                end
            end

            S_RD_ISSUE:
            begin
                mem_re     = 1'b1;
                mem_raddr  = back_reg ? (cnt_m1 - rd_i_reg) : rd_i_reg;
                state_next = S_RD_WAIT;
            end

            S_RD_WAIT:
            begin
                if (res_space)
                begin
                    res_push         = 1'b1;
                    res.read_value   = mem_rdata;
                    res.status       = ST_OK;
                    res.last         = rd_last;
                    res.entries_now  = ENT_W'(count_reg);
                    if (rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_i_next  = rd_i_reg + ADDR_W'(1);
                        state_next = S_RD_ISSUE;
                    end
                end
            end

            S_RESP:
            begin
                if (res_space)
                begin
                    res_push        = 1'b1;
                    res.read_value  = '0;
                    res.status      = status_reg;
                    res.last        = 1'b1;
                    res.entries_now = ENT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            issue_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            issue_reg <= issue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        stop_reg      <= stop_next;
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        rd_i_reg      <= rd_i_next;
        up_reg        <= up_next;
        back_reg      <= back_next;
        status_reg    <= status_next;
        val_reg       <= val_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_pend_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_SHIFT))
        else $error("pending write-back outside shift");

    a_push_space: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res_space)
        else $error("result pushed into full output register");

    a_rd_data_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_WAIT) |->
            ($past(state_reg) == S_RD_ISSUE || $past(state_reg) == S_RD_WAIT))
        else $error("read-out beat without a RAM read");
`endif

endmodule

`default_nettype wire

/* rtl/core/indexed_deque_store_top.sv */
`default_nettype none

// Indexed deque store: up to CAPACITY signed 32-bit entries packed in one RAM.
// Flow: a plain op (no shift) goes straight to its result; a shifting insert/remove first
// moves the affected entries through the RAM, one RAM read and write-back per cycle.
// Read-out: each element is a RAM read, then an output load. Throughput: one op at a
// time, next beat taken the cycle after its last result enters the output reg.
// Reset (rst_n low, async) empties the store; RAM contents are not cleared.
module indexed_deque_store_top (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [31:0] item_value, [38:32] position, [39] zero
    input  wire logic [3:0]  s_tuser,   // [3:0] kind

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // [31:0] read_value, [38:32] entries_now, [39] zero
    output logic      [1:0]  m_tuser,   // [1:0] status
    output logic             m_tlast    // last result of the op
);
    import idq_pkg::*;

    logic              res_push;
    logic              res_space;
    res_t              res_c;
    res_t              res_q;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [VAL_W-1:0]  mem_rdata;

    // sequencer
    idq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser[KIND_W-1:0]),
        .in_value  (s_tdata[VAL_W-1:0]),
        .in_pos    (s_tdata[VAL_W +: POS_W]),
        .res_push  (res_push),
        .res_space (res_space),
        .res       (res_c),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // entry storage, element 0 is the front
    idq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VAL_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // output register decouples the sequencer from m_tready
    idq_outreg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .res_in    (res_c),
        .space     (res_space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res_out   (res_q)
    );

    assign m_tdata = {1'b0, res_q.entries_now, res_q.read_value};
    assign m_tuser = res_q.status;
    assign m_tlast = res_q.last;

endmodule

`default_nettype wire
